/* hw/rtl/mco_pkg.sv */
// Shared types, codes and helpers for the matrix chain order core.
`timescale 1ns / 1ps
package mco_pkg;

   localparam int COST_W = 53;
   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_TOO_MANY = 2'd1;
   localparam logic [1:0] STATUS_NO_MATRICES = 2'd2;

   localparam logic KIND_COST = 1'b0;
   localparam logic KIND_SPLIT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STATUS,
      ST_RD_DI,
      ST_RD_DJ,
      ST_K_READ,
      ST_K_MUL1,
      ST_K_MUL2,
      ST_K_ACC,
      ST_WRITE,
      ST_COST,
      ST_POP,
      ST_EMIT
   } state_type;

   function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
      logic [COST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, COST_MAX}) ? COST_MAX : s[COST_W-1:0];
   endfunction

endpackage

/* hw/rtl/mco_if.sv */
// Valid/ready channel interfaces for dimension words and result words.
`timescale 1ns / 1ps
interface mco_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] dimension;
   logic        final_dimension;

   modport source (output valid, dimension, final_dimension, input ready);
   modport sink (input valid, dimension, final_dimension, output ready);
endinterface

interface mco_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [1:0]  status;
   logic [52:0] total_cost;
   logic [5:0]  interval_start;
   logic [4:0]  split_point;
   logic [5:0]  interval_end;
   logic        final_result;

   modport source (output valid, kind, status, total_cost, interval_start, split_point,
                   interval_end, final_result, input ready);
   modport sink (input valid, kind, status, total_cost, interval_start, split_point,
                 interval_end, final_result, output ready);
endinterface

/* hw/rtl/mco_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
module mco_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

/* hw/rtl/matrix_chain_order_core.sv */
// Matrix chain order core: loads dimensions, fills cost/split tables, walks the optimal tree.
//
// Usage: dimension words arrive on req_chan, one per accepted word; the word with
// final_dimension set closes the chain. n matrices take n+1 words. The core accepts
// one word per cycle while idle. After the last word the core fills the cost and split
// tables in RAM, one interval after another: each split candidate k passes through a
// RAM read, two registered multiplies, and a saturating add and compare; each interval
// also reads its two outer dimensions and writes its table entries. req_chan.ready
// is low from the last word until the last result word of the run is loaded into the
// output register. rsp_chan then carries the total cost word, followed by one split
// word per interval of the optimal tree in preorder; each split word passes through
// a pop state and an emit state. final_result marks the last word of a run. A chain
// that is too long or has no matrix answers with one status word. A stalled receiver
// holds the output register and the walk waits. Reset clears the control state and
// the dimension count; table RAMs hold garbage until written and need no clearing.
`timescale 1ns / 1ps
module matrix_chain_order_core
   import mco_pkg::*;
#(
   parameter int MAX_MATRICES = 32
) (
   input  logic        clock,
   input  logic        reset,
   mco_req_if.sink     req_chan,
   mco_rsp_if.source   rsp_chan
);
   localparam int IW  = $clog2(MAX_MATRICES);
   localparam int NW  = $clog2(MAX_MATRICES + 1);
   localparam int CW  = $clog2(MAX_MATRICES + 3);
   localparam int TAW = 2 * IW;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] n_ff, n_in, len_ff, len_in, i_ff, i_in, k_ff, k_in, bk_ff, bk_in;
   logic [15:0] di_ff, di_in, dj_ff, dj_in;
   logic [31:0] p1_ff, p1_in;
   logic [47:0] p_ff, p_in;
   logic [COST_W-1:0] sum_ff, sum_in, best_ff, best_in;
   logic [1:0] stat_ff, stat_in;
   logic [NW-1:0] sp_ff, sp_in;
   logic [4:0] ca_ff, ca_in, cb_ff, cb_in;
   logic [9:0] stack_ff [MAX_MATRICES];

   logic rsp_valid_ff, rsp_valid_in;
   logic o_kind_ff, o_fin_ff;
   logic [1:0] o_stat_ff;
   logic [COST_W-1:0] o_cost_ff;
   logic [5:0] o_start_ff, o_end_ff;
   logic [4:0] o_split_ff;

   logic out_load, o_kind, o_fin;
   logic [1:0] o_stat;
   logic [COST_W-1:0] o_cost;
   logic [5:0] o_start, o_end;
   logic [4:0] o_split;

   logic push_r, push_l;
   logic [9:0] push_r_val, push_l_val;
   logic [NW-1:0] sp1;

   logic req_acc, out_free;
   logic [CW-1:0] cnt_next;
   logic [NW-1:0] j_idx;
   logic [9:0] top;
   logic [4:0] pop_a, pop_b;

   logic dim_we;
   logic [NW-1:0] dim_raddr;
   logic [15:0] dim_rdata;
   logic tab_we;
   logic [TAW-1:0] ca_raddr, cb_raddr, sp_raddr, tab_waddr;
   logic [COST_W-1:0] ca_rdata, cb_rdata, cost_now;
   logic [NW-1:0] sp_rdata;

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign cnt_next = (cnt_ff < CW'(MAX_MATRICES + 2)) ? cnt_ff + 1'b1 : cnt_ff;
   assign j_idx = i_ff + len_ff - 1'b1;
   assign top = stack_ff[IW'(sp_ff - 1'b1)];
   assign pop_a = top[4:0];
   assign pop_b = top[9:5];
   assign cost_now = sat_add(sum_ff, {{(COST_W-48){1'b0}}, p_ff});

   assign dim_we = req_acc && (cnt_ff < CW'(MAX_MATRICES + 1));
   assign tab_we = (state_ff == ST_WRITE);
   assign tab_waddr = {IW'(i_ff), IW'(j_idx)};
   assign ca_raddr = {IW'(i_ff), IW'(k_ff)};
   assign cb_raddr = {IW'(k_ff + 1'b1), IW'(j_idx)};
   assign sp_raddr = (state_ff == ST_POP) ? {IW'(pop_a), IW'(pop_b)}
                                          : {IW'(ca_ff), IW'(cb_ff)};

   always_comb begin
      unique case (state_ff)
         ST_RD_DI: dim_raddr = i_ff;
         ST_RD_DJ: dim_raddr = j_idx + 1'b1;
         default:  dim_raddr = k_ff + 1'b1;
      endcase
   end

   mco_ram #(.WIDTH(16), .DEPTH(MAX_MATRICES + 1)) u_dim_ram (
      .clock(clock), .we(dim_we), .waddr(cnt_ff[NW-1:0]), .wdata(req_chan.dimension),
      .raddr(dim_raddr), .rdata(dim_rdata));

   // two copies of the cost table give two reads per cycle
   mco_ram #(.WIDTH(COST_W), .DEPTH(2 ** TAW)) u_cost_a_ram (
      .clock(clock), .we(tab_we), .waddr(tab_waddr), .wdata(best_ff),
      .raddr(ca_raddr), .rdata(ca_rdata));

   mco_ram #(.WIDTH(COST_W), .DEPTH(2 ** TAW)) u_cost_b_ram (
      .clock(clock), .we(tab_we), .waddr(tab_waddr), .wdata(best_ff),
      .raddr(cb_raddr), .rdata(cb_rdata));

   mco_ram #(.WIDTH(NW), .DEPTH(2 ** TAW)) u_split_ram (
      .clock(clock), .we(tab_we), .waddr(tab_waddr), .wdata(bk_ff + 1'b1),
      .raddr(sp_raddr), .rdata(sp_rdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; len_ff <= len_in; i_ff <= i_in; k_ff <= k_in; bk_ff <= bk_in;
      di_ff <= di_in; dj_ff <= dj_in; p1_ff <= p1_in; p_ff <= p_in;
      sum_ff <= sum_in; best_ff <= best_in; stat_ff <= stat_in;
      ca_ff <= ca_in; cb_ff <= cb_in;
      if (out_load) begin
         o_kind_ff <= o_kind; o_stat_ff <= o_stat; o_cost_ff <= o_cost;
         o_start_ff <= o_start; o_split_ff <= o_split; o_end_ff <= o_end;
         o_fin_ff <= o_fin;
      end
      if (push_r) begin
         stack_ff[IW'(sp_ff)] <= push_r_val;
      end
      if (push_l) begin
         stack_ff[IW'(sp1)] <= push_l_val;
      end
   end

   always_comb begin
      logic [COST_W-1:0] lhs, rhs;
      state_in = state_ff; cnt_in = cnt_ff; n_in = n_ff; len_in = len_ff;
      i_in = i_ff; k_in = k_ff; bk_in = bk_ff; di_in = di_ff; dj_in = dj_ff;
      p1_in = p1_ff; p_in = p_ff; sum_in = sum_ff; best_in = best_ff;
      stat_in = stat_ff; sp_in = sp_ff; ca_in = ca_ff; cb_in = cb_ff;
      out_load = 1'b0; o_kind = KIND_COST; o_stat = STATUS_OK; o_cost = '0;
      o_start = '0; o_split = '0; o_end = '0; o_fin = 1'b0;
      push_r = 1'b0; push_l = 1'b0; sp1 = sp_ff;
      push_r_val = {cb_ff, sp_rdata[4:0]};
      push_l_val = {sp_rdata[4:0] - 5'd1, ca_ff};
      lhs = (k_ff == i_ff) ? '0 : ca_rdata;
      rhs = (k_ff + 1'b1 == j_idx) ? '0 : cb_rdata;
      rsp_valid_in = rsp_chan.ready ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cnt_in = cnt_next;
               if (req_chan.final_dimension) begin
                  cnt_in = '0;
                  n_in = NW'(cnt_next - 1'b1);
                  len_in = NW'(2);
                  i_in = '0;
                  if (cnt_next > CW'(MAX_MATRICES + 1)) begin
                     stat_in = STATUS_TOO_MANY;
                     state_in = ST_STATUS;
                  end else if (cnt_next < CW'(2)) begin
                     stat_in = STATUS_NO_MATRICES;
                     state_in = ST_STATUS;
                  end else if (cnt_next == CW'(2)) begin
                     state_in = ST_COST;
                  end else begin
                     state_in = ST_RD_DI;
                  end
               end
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               out_load = 1'b1; o_stat = stat_ff; o_fin = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RD_DI: state_in = ST_RD_DJ;
         ST_RD_DJ: begin
            di_in = dim_rdata;
            k_in = i_ff;
            state_in = ST_K_READ;
         end
         ST_K_READ: begin
            // first candidate of an interval: the read data is still d[j+1]
            if (k_ff == i_ff) begin
               dj_in = dim_rdata;
            end
            state_in = ST_K_MUL1;
         end
         ST_K_MUL1: begin
            p1_in = di_ff * dim_rdata;
            sum_in = sat_add(lhs, rhs);
            state_in = ST_K_MUL2;
         end
         ST_K_MUL2: begin
            p_in = p1_ff * dj_ff;
            state_in = ST_K_ACC;
         end
         ST_K_ACC: begin
            if (k_ff == i_ff || cost_now < best_ff) begin
               best_in = cost_now;
               bk_in = k_ff;
            end
            if (k_ff + 1'b1 < j_idx) begin
               k_in = k_ff + 1'b1;
               state_in = ST_K_READ;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_RD_DI;
            if (i_ff + len_ff < n_ff) begin
               i_in = i_ff + 1'b1;
            end else if (len_ff < n_ff) begin
               len_in = len_ff + 1'b1;
               i_in = '0;
            end else begin
               state_in = ST_COST;
            end
         end
         ST_COST: begin
            if (out_free) begin
               out_load = 1'b1;
               o_cost = (n_ff == NW'(1)) ? '0 : best_ff;
               o_fin = (n_ff == NW'(1));
               if (n_ff == NW'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  push_r = 1'b1;
                  push_r_val = {5'(n_ff - 1'b1), 5'b0};
                  sp_in = NW'(1);
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               ca_in = pop_a;
               cb_in = pop_b;
               sp_in = sp_ff - 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               push_r = ({1'b0, cb_ff} > 6'(sp_rdata)) && (sp_ff < NW'(MAX_MATRICES));
               sp1 = sp_ff + NW'(push_r);
               push_l = (6'(sp_rdata - 1'b1) > {1'b0, ca_ff})
                        && (sp1 < NW'(MAX_MATRICES));
               sp_in = sp1 + NW'(push_l);
               out_load = 1'b1;
               o_kind = KIND_SPLIT;
               o_start = {1'b0, ca_ff} + 6'd1;
               o_split = sp_rdata[4:0];
               o_end = {1'b0, cb_ff} + 6'd1;
               o_fin = (sp_in == '0);
               state_in = o_fin ? ST_IDLE : ST_POP;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.kind           = o_kind_ff;
   assign rsp_chan.status         = o_stat_ff;
   assign rsp_chan.total_cost     = o_cost_ff;
   assign rsp_chan.interval_start = o_start_ff;
   assign rsp_chan.split_point    = o_split_ff;
   assign rsp_chan.interval_end   = o_end_ff;
   assign rsp_chan.final_result   = o_fin_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= NW'(MAX_MATRICES))
      else $error("interval stack overflow");

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_K_ACC |-> (k_ff >= i_ff && k_ff < j_idx))
      else $error("split candidate outside interval");

   a_split_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> (bk_ff >= i_ff && bk_ff < j_idx))
      else $error("chosen split outside interval");

   a_load_blocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_chan.ready)
      else $error("dimension word accepted while busy");
endmodule
